// ===== sv/tgr_pkg.sv =====
// shared types and constants of the touch gesture recognizer
package tgr_pkg;

	localparam int SLOT_COUNT_DEF = 5;
	localparam int QUEUE_DEPTH = 2;
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [2:0] FLAG_DOWN = 3'd0;
	localparam logic [2:0] FLAG_CONTACT = 3'd4;
	localparam logic [2:0] FLAG_LIFT = 3'd2;

	localparam logic [CFG_INDEX_W-1:0] CFG_VIEW_WIDTH = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_VIEW_HEIGHT = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_LONG_HOLD_MS = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_CLICK_MS = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] CFG_DOUBLE_CLICK_MS = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] CFG_CLOSE_RANGE_PX = 3'd5;

	typedef enum logic [1:0] {
		LE_IDLE,
		LE_START,
		LE_MOVE,
		LE_END
	} le_t;

	typedef enum logic [2:0] {
		EV_START,
		EV_MOVE,
		EV_END,
		EV_HOLD,
		EV_CLICK,
		EV_DCLICK
	} ev_t;

	typedef struct packed {
		logic [11:0] view_width;
		logic [11:0] view_height;
		logic [15:0] long_hold_ms;
		logic [15:0] click_ms;
		logic [15:0] double_click_ms;
		logic [11:0] close_range_px;
	} cfg_t;

	typedef struct packed {
		le_t         kind;
		logic [3:0]  id;
		logic [11:0] x;
		logic [11:0] y;
		logic [31:0] now;
		logic        scan_end;
	} rec_t;

endpackage

// ===== sv/tgr_if.sv =====
// channel interfaces: touch records in, gesture events out, register writes
interface tgr_in_if;
	logic        valid;
	logic        ready;
	logic [2:0]  raw_flag;
	logic [3:0]  finger_id;
	logic [11:0] raw_x;
	logic [11:0] raw_y;
	logic [31:0] now_ms;
	logic        scan_end;

	modport source (output valid, raw_flag, finger_id, raw_x, raw_y, now_ms, scan_end,
		input ready);
	modport sink (input valid, raw_flag, finger_id, raw_x, raw_y, now_ms, scan_end,
		output ready);
endinterface

interface tgr_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  event_code;
	logic [3:0]  out_id;
	logic [11:0] pos_x;
	logic [11:0] pos_y;
	logic [11:0] origin_x;
	logic [11:0] origin_y;
	logic        last_of_run;

	modport source (output valid, event_code, out_id, pos_x, pos_y, origin_x, origin_y,
		last_of_run, input ready);
	modport sink (input valid, event_code, out_id, pos_x, pos_y, origin_x, origin_y,
		last_of_run, output ready);
endinterface

interface tgr_cfg_if;
	import tgr_pkg::*;
	logic                   valid;
	logic                   ready;
	logic [CFG_INDEX_W-1:0] index;
	logic [CFG_DATA_W-1:0]  data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== sv/tgr_front.sv =====
// front end: mirrors coordinates, decodes the flag and queues records
module tgr_front #(
	parameter int SLOT_COUNT = tgr_pkg::SLOT_COUNT_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  tgr_pkg::cfg_t   cfg,
	tgr_in_if.sink          touch,
	output logic            head_valid,
	output tgr_pkg::rec_t   head,
	input  logic            pop
);
	import tgr_pkg::*;

	localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	rec_t          queue_q [QUEUE_DEPTH];
	logic [QW-1:0] wr_ptr_q;
	logic [QW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	rec_t rec;
	le_t  kind;
	logic keep;
	logic push;
	logic beat;

	always_comb begin
		unique case (touch.raw_flag)
			FLAG_DOWN: kind = LE_START;
			FLAG_CONTACT: kind = LE_MOVE;
			FLAG_LIFT: kind = LE_END;
			default: kind = LE_IDLE;
		endcase
		keep = (kind != LE_IDLE) && (touch.finger_id < 4'(SLOT_COUNT));
		rec.kind = keep ? kind : LE_IDLE;
		rec.id = touch.finger_id;
		rec.x = (touch.raw_x > cfg.view_width) ? 12'd0 : cfg.view_width - touch.raw_x;
		rec.y = (touch.raw_y > cfg.view_height) ? 12'd0 : cfg.view_height - touch.raw_y;
		rec.now = touch.now_ms;
		rec.scan_end = touch.scan_end;
	end

	assign touch.ready = (count_q != CW'(QUEUE_DEPTH));
	assign beat = touch.valid && touch.ready;
	// dropped records that carry no end of scan need no queue slot
	assign push = beat && (keep || touch.scan_end);
	assign head_valid = (count_q != '0);
	assign head = queue_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= rec;
		end
	end

endmodule

// ===== sv/tgr_back.sv =====
// back end: per-slot state, gesture decisions and the output register
module tgr_back #(
	parameter int SLOT_COUNT = tgr_pkg::SLOT_COUNT_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  tgr_pkg::cfg_t   cfg,
	input  logic            head_valid,
	input  tgr_pkg::rec_t   head,
	output logic            pop,
	tgr_out_if.source       evt
);
	import tgr_pkg::*;

	localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

	typedef enum logic {
		PH_FIRST,
		PH_SECOND
	} phase_t;

	phase_t      phase_q;
	logic        out_valid_q;
	ev_t         code_q;
	logic [3:0]  id_q;
	logic [11:0] pos_x_q;
	logic [11:0] pos_y_q;
	logic [11:0] origin_x_q;
	logic [11:0] origin_y_q;
	logic        last_q;

	logic [31:0] start_time_q [SLOT_COUNT];
	logic [31:0] prev_click_q [SLOT_COUNT];
	logic [11:0] start_x_q [SLOT_COUNT];
	logic [11:0] start_y_q [SLOT_COUNT];
	logic [11:0] cur_x_q [SLOT_COUNT];
	logic [11:0] cur_y_q [SLOT_COUNT];
	le_t         last_event_q [SLOT_COUNT];
	logic        hold_q [SLOT_COUNT];
	logic        moved_q [SLOT_COUNT];

	logic [SLOT_W-1:0] s;
	logic [31:0]       dt_start;
	logic [31:0]       dt_click;
	logic [11:0]       dx;
	logic [11:0]       dy;
	logic              close;
	logic              has_ev;
	logic              hold_hit;
	logic              dclick_hit;
	logic              click_hit;
	logic              pre;
	ev_t               pre_code;
	ev_t               main_code;
	logic              can_issue;
	logic              issue;
	logic              first_of_two;
	logic              clear_vec [SLOT_COUNT];

	always_comb begin
		s = head.id[SLOT_W-1:0];
		dt_start = head.now - start_time_q[s];
		dt_click = head.now - prev_click_q[s];
		dx = (cur_x_q[s] > start_x_q[s]) ? cur_x_q[s] - start_x_q[s] : start_x_q[s] - cur_x_q[s];
		dy = (cur_y_q[s] > start_y_q[s]) ? cur_y_q[s] - start_y_q[s] : start_y_q[s] - cur_y_q[s];
		close = (dx <= cfg.close_range_px) && (dy <= cfg.close_range_px);
		has_ev = (head.kind != LE_IDLE);
		hold_hit = (head.kind == LE_MOVE) && (dt_start > {16'd0, cfg.long_hold_ms}) &&
			!moved_q[s] && !hold_q[s];
		dclick_hit = (head.kind == LE_END) && (dt_click < {16'd0, cfg.double_click_ms});
		click_hit = (head.kind == LE_END) && !dclick_hit &&
			(dt_start < {16'd0, cfg.click_ms}) && close;
		pre = hold_hit || dclick_hit || click_hit;
		priority if (hold_hit) begin
			pre_code = EV_HOLD;
		end else if (dclick_hit) begin
			pre_code = EV_DCLICK;
		end else begin
			pre_code = EV_CLICK;
		end
		unique case (head.kind)
			LE_START: main_code = EV_START;
			LE_MOVE: main_code = EV_MOVE;
			default: main_code = EV_END;
		endcase
		can_issue = !out_valid_q || evt.ready;
		issue = head_valid && can_issue;
		first_of_two = has_ev && pre && (phase_q == PH_FIRST);
		pop = issue && !first_of_two;
		for (int i = 0; i < SLOT_COUNT; i++) begin
			clear_vec[i] = (has_ev && SLOT_W'(i) == s) ? (head.kind == LE_END) :
				(last_event_q[i] == LE_END);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_FIRST;
			out_valid_q <= 1'b0;
			code_q <= EV_START;
			id_q <= '0;
			pos_x_q <= '0;
			pos_y_q <= '0;
			origin_x_q <= '0;
			origin_y_q <= '0;
			last_q <= 1'b0;
			for (int i = 0; i < SLOT_COUNT; i++) begin
				start_time_q[i] <= '0;
				prev_click_q[i] <= '0;
				start_x_q[i] <= '0;
				start_y_q[i] <= '0;
				cur_x_q[i] <= '0;
				cur_y_q[i] <= '0;
				last_event_q[i] <= LE_IDLE;
				hold_q[i] <= 1'b0;
				moved_q[i] <= 1'b0;
			end
		end else begin
			if (issue && first_of_two) begin
				// leading hold, click or double click beat, slot state left as it was
				out_valid_q <= 1'b1;
				code_q <= pre_code;
				id_q <= head.id;
				pos_x_q <= cur_x_q[s];
				pos_y_q <= cur_y_q[s];
				origin_x_q <= start_x_q[s];
				origin_y_q <= start_y_q[s];
				last_q <= 1'b0;
				phase_q <= PH_SECOND;
			end else if (issue) begin
				phase_q <= PH_FIRST;
				out_valid_q <= has_ev;
				if (has_ev) begin
					code_q <= main_code;
					id_q <= head.id;
					pos_x_q <= head.x;
					pos_y_q <= head.y;
					origin_x_q <= (head.kind == LE_START) ? head.x : start_x_q[s];
					origin_y_q <= (head.kind == LE_START) ? head.y : start_y_q[s];
					last_q <= 1'b1;
					unique case (head.kind)
						LE_START: begin
							start_time_q[s] <= head.now;
							start_x_q[s] <= head.x;
							start_y_q[s] <= head.y;
						end
						LE_MOVE: begin
							if (hold_hit) begin
								hold_q[s] <= 1'b1;
							end
							if (!close) begin
								moved_q[s] <= 1'b1;
							end
						end
						default: begin
							if (click_hit) begin
								prev_click_q[s] <= head.now;
							end
						end
					endcase
					cur_x_q[s] <= head.x;
					cur_y_q[s] <= head.y;
					last_event_q[s] <= (head.scan_end && head.kind == LE_END) ? LE_IDLE :
						head.kind;
				end
				if (head.scan_end) begin
					for (int i = 0; i < SLOT_COUNT; i++) begin
						if (clear_vec[i]) begin
							if (!(has_ev && SLOT_W'(i) == s)) begin
								last_event_q[i] <= LE_IDLE;
							end
							hold_q[i] <= 1'b0;
							moved_q[i] <= 1'b0;
						end
					end
				end
			end else if (evt.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign evt.valid = out_valid_q;
	assign evt.event_code = code_q;
	assign evt.out_id = id_q;
	assign evt.pos_x = pos_x_q;
	assign evt.pos_y = pos_y_q;
	assign evt.origin_x = origin_x_q;
	assign evt.origin_y = origin_y_q;
	assign evt.last_of_run = last_q;

endmodule

// ===== sv/touch_gesture_recognizer.sv =====
// top level of the touch gesture recognizer with its register bank
// Takes one touch-slot record per beat on touch and gives Start, Move and End events on evt,
// each preceded by a LongHold, Click or DoubleClick beat when the timing and distance rules are met;
// last_of_run marks the final beat of a record. Coordinates are mirrored against the screen
// size and clamp at 0. A record with a leading gesture beat gives two beats on evt, and an
// ignored record gives none and takes no queue slot when it carries no end of scan; the
// single output register issues one beat per cycle while evt is ready. A two-entry record
// queue separates input from the back end, so input is taken while an event waits on evt
// until the queue is full. A record passes the queue and then the output register. Registers
// are written through cfg (always ready) and should only change while the block is idle.
module touch_gesture_recognizer #(
	parameter int SLOT_COUNT = tgr_pkg::SLOT_COUNT_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	tgr_in_if.sink    touch,
	tgr_out_if.source evt,
	tgr_cfg_if.sink   cfg
);
	import tgr_pkg::*;

	cfg_t cfg_q;
	logic head_valid;
	rec_t head;
	logic pop;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.view_width <= 12'd1024;
			cfg_q.view_height <= 12'd600;
			cfg_q.long_hold_ms <= 16'd1000;
			cfg_q.click_ms <= 16'd300;
			cfg_q.double_click_ms <= 16'd400;
			cfg_q.close_range_px <= 12'd10;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_VIEW_WIDTH: cfg_q.view_width <= cfg.data[11:0];
				CFG_VIEW_HEIGHT: cfg_q.view_height <= cfg.data[11:0];
				CFG_LONG_HOLD_MS: cfg_q.long_hold_ms <= cfg.data;
				CFG_CLICK_MS: cfg_q.click_ms <= cfg.data;
				CFG_DOUBLE_CLICK_MS: cfg_q.double_click_ms <= cfg.data;
				CFG_CLOSE_RANGE_PX: cfg_q.close_range_px <= cfg.data[11:0];
				default: ;
			endcase
		end
	end

	tgr_front #(
		.SLOT_COUNT(SLOT_COUNT)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.touch(touch),
		.head_valid(head_valid),
		.head(head),
		.pop(pop)
	);

	tgr_back #(
		.SLOT_COUNT(SLOT_COUNT)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.head_valid(head_valid),
		.head(head),
		.pop(pop),
		.evt(evt)
	);

`ifndef SYNTHESIS
	a_lead_is_gesture: assert property (@(posedge clk) disable iff (!arst_n)
		evt.valid && !evt.last_of_run |->
		(evt.event_code == EV_HOLD || evt.event_code == EV_CLICK ||
		evt.event_code == EV_DCLICK))
		else $error("leading beat is not a gesture event");

	a_last_is_main: assert property (@(posedge clk) disable iff (!arst_n)
		evt.valid && evt.last_of_run |->
		(evt.event_code == EV_START || evt.event_code == EV_MOVE ||
		evt.event_code == EV_END))
		else $error("final beat is not a start, move or end event");

	a_pop_needs_head: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("queue popped while empty");

	a_lead_holds_record: assert property (@(posedge clk) disable iff (!arst_n)
		evt.valid && !evt.last_of_run |-> head_valid && head.kind != LE_IDLE)
		else $error("record after a gesture beat lost its event");
`endif

endmodule

// ===== tb/tgr_event_checker.sv =====
// event checker: tracks register writes, predicts events per touch record, compares beats
module tgr_event_checker
	import tgr_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	tgr_in_if    touch,
	tgr_out_if   evt,
	tgr_cfg_if   cfg,
	output int   fails,
	output int   pending,
	output int   beats
);

	localparam int SLOTS = SLOT_COUNT_DEF;

	typedef struct packed {
		ev_t         code;
		logic [3:0]  id;
		logic [11:0] px;
		logic [11:0] py;
		logic [11:0] ox;
		logic [11:0] oy;
		logic        last;
	} gesture_t;

	gesture_t expected_q[$];
	cfg_t     regs;

	logic [31:0] t0 [SLOTS];
	logic [31:0] click_t [SLOTS];
	logic [11:0] org_x [SLOTS];
	logic [11:0] org_y [SLOTS];
	logic [11:0] at_x [SLOTS];
	logic [11:0] at_y [SLOTS];
	le_t         phase [SLOTS];
	logic        held [SLOTS];
	logic        wandered [SLOTS];

	function automatic logic [11:0] mirror(logic [11:0] size, logic [11:0] raw);
		return (raw > size) ? 12'd0 : size - raw;
	endfunction

	function automatic logic near(int s);
		logic [11:0] dx, dy;
		dx = (at_x[s] > org_x[s]) ? at_x[s] - org_x[s] : org_x[s] - at_x[s];
		dy = (at_y[s] > org_y[s]) ? at_y[s] - org_y[s] : org_y[s] - at_y[s];
		return dx <= regs.close_range_px && dy <= regs.close_range_px;
	endfunction

	function automatic void push_event(ev_t code, int s, logic last);
		expected_q.push_back('{code: code, id: 4'(s), px: at_x[s], py: at_y[s],
			ox: org_x[s], oy: org_y[s], last: last});
	endfunction

	task automatic report(string msg);
		if (fails < 10) begin
			$display("%s", msg);
		end
		fails++;
	endtask

	always @(posedge clk or negedge arst_n) begin : model
		gesture_t    want;
		le_t         kind;
		ev_t         code;
		logic [11:0] nx, ny;
		logic [31:0] elapsed;
		int          s;
		if (!arst_n) begin
			expected_q.delete();
			regs.view_width = 12'd1024;
			regs.view_height = 12'd600;
			regs.long_hold_ms = 16'd1000;
			regs.click_ms = 16'd300;
			regs.double_click_ms = 16'd400;
			regs.close_range_px = 12'd10;
			for (int i = 0; i < SLOTS; i++) begin
				t0[i] = '0;
				click_t[i] = '0;
				org_x[i] = '0;
				org_y[i] = '0;
				at_x[i] = '0;
				at_y[i] = '0;
				phase[i] = LE_IDLE;
				held[i] = 1'b0;
				wandered[i] = 1'b0;
			end
			fails = 0;
			beats = 0;
			pending = 0;
		end else begin
			// results first, so a beat can never match a record taken in the same cycle
			if (evt.valid && evt.ready) begin
				beats++;
				if (expected_q.size() == 0) begin
					report($sformatf("beat %0d: unexpected event code %0d id %0d pos %0d,%0d",
						beats, evt.event_code, evt.out_id, evt.pos_x, evt.pos_y));
				end else begin
					want = expected_q.pop_front();
					if (evt.event_code !== want.code || evt.out_id !== want.id ||
						evt.pos_x !== want.px || evt.pos_y !== want.py ||
						evt.origin_x !== want.ox || evt.origin_y !== want.oy ||
						evt.last_of_run !== want.last) begin
						report($sformatf({"beat %0d: expected code %0d id %0d pos %0d,%0d ",
							"origin %0d,%0d last %0b; got code %0d id %0d pos %0d,%0d ",
							"origin %0d,%0d last %0b"}, beats, want.code, want.id, want.px,
							want.py, want.ox, want.oy, want.last, evt.event_code, evt.out_id,
							evt.pos_x, evt.pos_y, evt.origin_x, evt.origin_y, evt.last_of_run));
					end
				end
			end

			if (touch.valid && touch.ready) begin
				kind = LE_IDLE;
				code = EV_START;
				case (touch.raw_flag)
					FLAG_DOWN: begin
						kind = LE_START;
						code = EV_START;
					end
					FLAG_CONTACT: begin
						kind = LE_MOVE;
						code = EV_MOVE;
					end
					FLAG_LIFT: begin
						kind = LE_END;
						code = EV_END;
					end
					default: ;
				endcase
				nx = mirror(regs.view_width, touch.raw_x);
				ny = mirror(regs.view_height, touch.raw_y);
				s = int'(touch.finger_id);
				if (s < SLOTS && kind != LE_IDLE) begin
					case (kind)
						LE_START: begin
							t0[s] = touch.now_ms;
							org_x[s] = nx;
							org_y[s] = ny;
						end
						LE_MOVE: begin
							elapsed = touch.now_ms - t0[s];
							if (elapsed > 32'(regs.long_hold_ms) && !wandered[s] && !held[s]) begin
								held[s] = 1'b1;
								push_event(EV_HOLD, s, 1'b0);
							end
							if (!near(s)) begin
								wandered[s] = 1'b1;
							end
						end
						default: begin
							elapsed = touch.now_ms - click_t[s];
							if (elapsed < 32'(regs.double_click_ms)) begin
								push_event(EV_DCLICK, s, 1'b0);
							end else begin
								elapsed = touch.now_ms - t0[s];
								if (elapsed < 32'(regs.click_ms) && near(s)) begin
									click_t[s] = touch.now_ms;
									push_event(EV_CLICK, s, 1'b0);
								end
							end
						end
					endcase
					at_x[s] = nx;
					at_y[s] = ny;
					phase[s] = kind;
					push_event(code, s, 1'b1);
				end
				// end of scan frees lifted fingers, even on an ignored record
				if (touch.scan_end) begin
					for (int i = 0; i < SLOTS; i++) begin
						if (phase[i] == LE_END) begin
							phase[i] = LE_IDLE;
							held[i] = 1'b0;
							wandered[i] = 1'b0;
						end
					end
				end
			end

			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					CFG_VIEW_WIDTH: regs.view_width = cfg.data[11:0];
					CFG_VIEW_HEIGHT: regs.view_height = cfg.data[11:0];
					CFG_LONG_HOLD_MS: regs.long_hold_ms = cfg.data;
					CFG_CLICK_MS: regs.click_ms = cfg.data;
					CFG_DOUBLE_CLICK_MS: regs.double_click_ms = cfg.data;
					CFG_CLOSE_RANGE_PX: regs.close_range_px = cfg.data[11:0];
					default: ;
				endcase
			end

			pending = expected_q.size();
		end
	end

endmodule

// ===== tb/tb_touch_gesture_recognizer.sv =====
// testbench top: touch record stimulus, register settings, random stalls and the verdict
module tb_touch_gesture_recognizer;
	import tgr_pkg::*;

	localparam int SLOTS = SLOT_COUNT_DEF;
	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_WAIT = 8;
	localparam int PHASES = 7;
	localparam int PHASE_RECORDS = 230;

	logic clk = 1'b0;
	logic arst_n;
	logic steady;
	int   fails, pending, beats;
	int   cycles = 0;
	int   records = 0;
	int   ignored = 0;
	int   settings = 1;

	logic [31:0] t_ms;
	int          w_cur, hold_cur, click_cur, dclick_cur, near_cur;
	logic        down [SLOTS];
	logic [11:0] base_x [SLOTS];
	logic [11:0] base_y [SLOTS];

	tgr_in_if  touch_ch();
	tgr_out_if evt_ch();
	tgr_cfg_if cfg_ch();

	touch_gesture_recognizer dut (
		.clk    (clk),
		.arst_n (arst_n),
		.touch  (touch_ch),
		.evt    (evt_ch),
		.cfg    (cfg_ch)
	);

	tgr_event_checker chk (
		.clk     (clk),
		.arst_n  (arst_n),
		.touch   (touch_ch),
		.evt     (evt_ch),
		.cfg     (cfg_ch),
		.fails   (fails),
		.pending (pending),
		.beats   (beats)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d events outstanding", cycles, pending);
			$display("Simulation FAILED");
			$finish;
		end
	end

	always @(negedge clk) begin
		evt_ch.ready = steady || ($urandom_range(99) >= 23);
	end

	task automatic put(logic [2:0] flag, logic [3:0] id, logic [11:0] rx, logic [11:0] ry,
		logic [31:0] t, logic se);
		while (!steady && $urandom_range(99) < 23) begin
			touch_ch.valid = 1'b0;
			@(negedge clk);
		end
		touch_ch.raw_flag = flag;
		touch_ch.finger_id = id;
		touch_ch.raw_x = rx;
		touch_ch.raw_y = ry;
		touch_ch.now_ms = t;
		touch_ch.scan_end = se;
		touch_ch.valid = 1'b1;
		do @(posedge clk); while (!touch_ch.ready);
		@(negedge clk);
		if ((flag == FLAG_DOWN || flag == FLAG_CONTACT || flag == FLAG_LIFT) && id < SLOTS) begin
			records++;
		end else begin
			ignored++;
		end
	endtask

	// sender holds off until every event is out and the back end has gone quiet
	task automatic settle();
		touch_ch.valid = 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (DRAIN_WAIT) @(negedge clk);
	endtask

	task automatic write_setting(int w, int h, int hold, int click, int dclick, int near_px);
		logic [CFG_INDEX_W-1:0] idx [6];
		int                     val [6];
		idx = '{CFG_VIEW_WIDTH, CFG_VIEW_HEIGHT, CFG_LONG_HOLD_MS, CFG_CLICK_MS,
			CFG_DOUBLE_CLICK_MS, CFG_CLOSE_RANGE_PX};
		val = '{w, h, hold, click, dclick, near_px};
		for (int i = 0; i < 6; i++) begin
			cfg_ch.index = idx[i];
			cfg_ch.data = val[i][15:0];
			cfg_ch.valid = 1'b1;
			do @(posedge clk); while (!cfg_ch.ready);
			@(negedge clk);
		end
		cfg_ch.valid = 1'b0;
		w_cur = w;
		hold_cur = hold;
		click_cur = click;
		dclick_cur = dclick;
		near_cur = near_px;
		settings++;
	endtask

	// time step between scans, biased towards the gesture thresholds
	function automatic logic [31:0] pick_gap();
		int r;
		int g;
		r = $urandom_range(99);
		if (r >= 93) begin
			return $urandom;
		end
		if (r < 35) g = $urandom_range(60);
		else if (r < 50) g = click_cur + int'($urandom_range(6)) - 3;
		else if (r < 60) g = dclick_cur + int'($urandom_range(6)) - 3;
		else if (r < 75) g = hold_cur + int'($urandom_range(6)) - 3;
		else g = $urandom_range(2000);
		return (g < 0) ? 32'd0 : 32'(g);
	endfunction

	function automatic logic [11:0] nudge(logic [11:0] v, int j);
		int p;
		p = int'(v) + int'($urandom_range(2 * j)) - j;
		if (p < 0) p = 0;
		if (p > 4095) p = 4095;
		return p[11:0];
	endfunction

	task automatic run_scans(int target);
		int          done, n, pick, jit;
		logic [3:0]  id;
		logic [2:0]  flag;
		logic [11:0] rx, ry;
		logic        se;
		done = 0;
		while (done < target) begin
			t_ms = t_ms + pick_gap();
			n = $urandom_range(1, 4);
			for (int k = 0; k < n; k++) begin
				se = (k == n - 1);
				if ($urandom_range(99) < 8) begin
					// noise: a flag with no meaning, or a finger beyond the slots
					if ($urandom_range(1)) begin
						do flag = 3'($urandom_range(7));
						while (flag == FLAG_DOWN || flag == FLAG_CONTACT || flag == FLAG_LIFT);
						id = 4'($urandom_range(15));
					end else begin
						flag = 3'($urandom_range(7));
						id = 4'($urandom_range(SLOTS, 15));
					end
					put(flag, id, 12'($urandom_range(4095)), 12'($urandom_range(4095)), t_ms, se);
				end else begin
					id = 4'($urandom_range(SLOTS - 1));
					pick = $urandom_range(99);
					if (!down[id]) begin
						flag = (pick < 88) ? FLAG_DOWN : ((pick < 94) ? FLAG_CONTACT : FLAG_LIFT);
					end else begin
						flag = (pick < 55) ? FLAG_CONTACT : ((pick < 95) ? FLAG_LIFT : FLAG_DOWN);
					end
					if (flag == FLAG_DOWN) begin
						base_x[id] = $urandom_range(1) ? 12'($urandom_range(4095)) :
							12'($urandom_range(w_cur));
						base_y[id] = 12'($urandom_range(4095));
						rx = base_x[id];
						ry = base_y[id];
					end else if ($urandom_range(99) < 70) begin
						jit = (near_cur + 2 > 40) ? 40 : near_cur + 2;
						rx = nudge(base_x[id], jit);
						ry = nudge(base_y[id], jit);
					end else begin
						rx = 12'($urandom_range(4095));
						ry = 12'($urandom_range(4095));
					end
					down[id] = (flag != FLAG_LIFT);
					put(flag, id, rx, ry, t_ms, se);
					done++;
				end
			end
		end
	endtask

	task automatic directed();
		// click, then double click on the same finger
		put(FLAG_DOWN, 4'd0, 12'd24, 12'd0, 32'd1000, 1'b1);
		put(FLAG_LIFT, 4'd0, 12'd26, 12'd3, 32'd1100, 1'b1);
		put(FLAG_DOWN, 4'd0, 12'd24, 12'd0, 32'd1200, 1'b1);
		put(FLAG_LIFT, 4'd0, 12'd24, 12'd0, 32'd1250, 1'b1);
		// coordinates past the screen clamp to 0; hold exactly at and just past the limit
		put(FLAG_DOWN, 4'd1, 12'd4095, 12'd4095, 32'd5000, 1'b0);
		put(FLAG_CONTACT, 4'd1, 12'd4090, 12'd4095, 32'd6000, 1'b1);
		put(FLAG_CONTACT, 4'd1, 12'd4095, 12'd4095, 32'd6001, 1'b1);
		// lift without end of scan, cleared by an ignored record that ends the scan
		put(FLAG_LIFT, 4'd1, 12'd4095, 12'd4095, 32'd6100, 1'b0);
		put(3'd7, 4'd2, 12'd0, 12'd0, 32'd6100, 1'b1);
		put(FLAG_DOWN, 4'd15, 12'd100, 12'd100, 32'd6100, 1'b0);
		put(3'd1, 4'd2, 12'd100, 12'd100, 32'd6100, 1'b0);
		put(3'd3, 4'd2, 12'd100, 12'd100, 32'd6100, 1'b0);
		put(3'd5, 4'd2, 12'd100, 12'd100, 32'd6100, 1'b0);
		put(3'd6, 4'd5, 12'd100, 12'd100, 32'd6100, 1'b1);
		// move and lift with no press first
		put(FLAG_CONTACT, 4'd3, 12'd100, 12'd100, 32'h8000_0000, 1'b1);
		put(FLAG_LIFT, 4'd4, 12'd0, 12'd0, 32'h8000_0010, 1'b1);
		// long hold across the wrap of the millisecond counter
		put(FLAG_DOWN, 4'd2, 12'd1024, 12'd600, 32'hFFFF_FF80, 1'b1);
		put(FLAG_CONTACT, 4'd2, 12'd1014, 12'd590, 32'h0000_0400, 1'b1);
		put(FLAG_LIFT, 4'd2, 12'd1024, 12'd600, 32'h0000_0410, 1'b1);
		// a finger that moved away gets no long hold
		put(FLAG_DOWN, 4'd3, 12'd500, 12'd300, 32'h0001_0000, 1'b1);
		put(FLAG_CONTACT, 4'd3, 12'd400, 12'd300, 32'h0001_0010, 1'b1);
		put(FLAG_CONTACT, 4'd3, 12'd400, 12'd300, 32'h0001_0020, 1'b1);
		put(FLAG_CONTACT, 4'd3, 12'd400, 12'd300, 32'h0001_0500, 1'b1);
		put(FLAG_LIFT, 4'd3, 12'd500, 12'd300, 32'h0001_0520, 1'b1);
		// press held exactly the click time is no click
		put(FLAG_DOWN, 4'd0, 12'd24, 12'd0, 32'h0002_0000, 1'b1);
		put(FLAG_LIFT, 4'd0, 12'd24, 12'd0, 32'h0002_012C, 1'b1);
	endtask

	initial begin
		arst_n = 1'b0;
		steady = 1'b0;
		touch_ch.valid = 1'b0;
		touch_ch.raw_flag = '0;
		touch_ch.finger_id = '0;
		touch_ch.raw_x = '0;
		touch_ch.raw_y = '0;
		touch_ch.now_ms = '0;
		touch_ch.scan_end = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = '0;
		cfg_ch.data = '0;
		t_ms = 32'h0003_0000;
		w_cur = 1024;
		hold_cur = 1000;
		click_cur = 300;
		dclick_cur = 400;
		near_cur = 10;
		for (int i = 0; i < SLOTS; i++) begin
			down[i] = 1'b0;
			base_x[i] = '0;
			base_y[i] = '0;
		end
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		directed();
		for (int ph = 0; ph < PHASES; ph++) begin
			settle();
			case (ph)
				0: ;
				1: write_setting(4095, 4095, 65535, 65535, 65535, 4095);
				2: write_setting(0, 0, 0, 0, 0, 0);
				5: write_setting($urandom_range(4095), $urandom_range(4095), $urandom_range(65535),
					$urandom_range(65535), $urandom_range(65535), $urandom_range(4095));
				default: write_setting($urandom_range(4095), $urandom_range(4095),
					$urandom_range(50, 3000), $urandom_range(2000), $urandom_range(2000),
					$urandom_range(60));
			endcase
			steady = (ph == 2);
			run_scans(PHASE_RECORDS);
		end
		steady = 1'b0;
		settle();

		$display("%0d touch records and %0d ignored records over %0d register settings",
			records, ignored, settings);
		$display("%0d event beats compared, %0d failures", beats, fails);
		if (fails == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
